// ----- rtl/sbt_pkg.sv -----
// Shared types, token codes and decode functions for the source byte tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package sbt_pkg;

	localparam int NUMBER_BITS = 32;
	localparam int LINE_BITS   = 16;
	localparam int KW_BITS     = 40;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

	localparam logic [4:0] KIND_PRINT  = 5'd0;
	localparam logic [4:0] KIND_LET    = 5'd1;
	localparam logic [4:0] KIND_IF     = 5'd2;
	localparam logic [4:0] KIND_WHILE  = 5'd3;
	localparam logic [4:0] KIND_FN     = 5'd4;
	localparam logic [4:0] KIND_RET    = 5'd5;
	localparam logic [4:0] KIND_IDENT  = 5'd6;
	localparam logic [4:0] KIND_NUMBER = 5'd7;
	localparam logic [4:0] KIND_SEMI   = 5'd8;
	localparam logic [4:0] KIND_QUOTE  = 5'd9;
	localparam logic [4:0] KIND_PLUS   = 5'd10;
	localparam logic [4:0] KIND_MINUS  = 5'd11;
	localparam logic [4:0] KIND_STAR   = 5'd12;
	localparam logic [4:0] KIND_SLASH  = 5'd13;
	localparam logic [4:0] KIND_EQ     = 5'd14;
	localparam logic [4:0] KIND_EQEQ   = 5'd15;
	localparam logic [4:0] KIND_LPAREN = 5'd16;
	localparam logic [4:0] KIND_RPAREN = 5'd17;
	localparam logic [4:0] KIND_COMMA  = 5'd18;
	localparam logic [4:0] KIND_LBRACK = 5'd19;
	localparam logic [4:0] KIND_RBRACK = 5'd20;
	localparam logic [4:0] KIND_AT     = 5'd21;
	localparam logic [4:0] KIND_ERROR  = 5'd22;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	localparam logic [NUMBER_BITS-1:0] NUM_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_input;
	} tok_in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] number_value;
		logic [7:0]  name_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} tok_out_t;

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_NAME    = 6'b000010,
		MODE_NUM     = 6'b000100,
		MODE_EQ      = 6'b001000,
		MODE_COMMENT = 6'b010000,
		MODE_HALT    = 6'b100000
	} mode_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Single-character tokens; anything unlisted maps to the error kind.
	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h3B:   k = KIND_SEMI;
			8'h27:   k = KIND_QUOTE;
			8'h2B:   k = KIND_PLUS;
			8'h2D:   k = KIND_MINUS;
			8'h2A:   k = KIND_STAR;
			8'h2F:   k = KIND_SLASH;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h2C:   k = KIND_COMMA;
			8'h5B:   k = KIND_LBRACK;
			8'h5D:   k = KIND_RBRACK;
			8'h40:   k = KIND_AT;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] name_kind(input logic [KW_BITS-1:0] kw,
			input logic [7:0] len);
		logic [4:0] k;
		k = KIND_IDENT;
		if (len == 8'd5 && kw == 40'h7072696E74) k = KIND_PRINT;
		else if (len == 8'd3 && kw == 40'h00006C6574) k = KIND_LET;
		else if (len == 8'd2 && kw == 40'h0000006966) k = KIND_IF;
		else if (len == 8'd5 && kw == 40'h7768696C65) k = KIND_WHILE;
		else if (len == 8'd2 && kw == 40'h000000666E) k = KIND_FN;
		else if (len == 8'd3 && kw == 40'h0000726574) k = KIND_RET;
		return k;
	endfunction

	// acc * 10 + digit, sticking at all ones on overflow.
	function automatic logic [NUMBER_BITS-1:0] add_digit(
			input logic [NUMBER_BITS-1:0] acc, input logic [7:0] c);
		logic [NUMBER_BITS+3:0] w;
		logic [3:0]             d;
		d = 4'(c - 8'h30);
		w = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUMBER_BITS{1'b0}}, d};
		return (w[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) ? NUM_MAX : w[NUMBER_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/source_byte_tokenizer.sv -----
// Source byte tokenizer: one-byte-per-cycle scanner gated by in_ready, with a small result queue.
// Tokens from a byte enter the result queue as the byte is taken and drain while out_ready is high.
// Throughput: one byte per cycle while in_ready is high; a byte can yield two tokens, which drain
// from a four-entry queue at one per cycle, and in_ready drops while fewer than two slots are free.
// Reset: arst_n clears the scan mode to idle, the queue to empty and the line counter to one.
`timescale 1ns / 1ps
`default_nettype none
module source_byte_tokenizer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  sbt_pkg::tok_in_t      in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output sbt_pkg::tok_out_t     out_data
);
	import sbt_pkg::*;

	mode_t                  mode_q, mode_d;
	logic [KW_BITS-1:0]     kw_q, kw_d;
	logic [7:0]             run_q, run_d;
	logic [NUMBER_BITS-1:0] acc_q, acc_d;
	logic [LINE_BITS-1:0]   line_q, line_d;

	tok_out_t               fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]    count_q;

	tok_out_t               tok0, tok1, flush_tok, char_tok;
	logic                   flush_vld, char_vld;
	logic [1:0]             push_n;
	logic                   accept, pop;
	logic [7:0]             c;

	assign accept    = in_valid && in_ready;
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign in_ready  = count_q <= CNT_BITS'(FIFO_DEPTH - 2);
	assign out_data  = fifo_q[rd_ptr_q];
	assign c         = in_data.source_byte;

	// pending token that a delimiter or end of input would close
	always_comb begin
		flush_tok             = '0;
		flush_tok.line_number = line_q;
		flush_vld             = 1'b1;
		unique case (mode_q)
			MODE_NAME: begin
				flush_tok.token_kind  = name_kind(kw_q, run_q);
				flush_tok.name_length = run_q;
			end
			MODE_NUM: begin
				flush_tok.token_kind   = KIND_NUMBER;
				flush_tok.number_value = acc_q;
			end
			MODE_EQ: flush_tok.token_kind = KIND_EQ;
			default: flush_vld = 1'b0;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		kw_d     = kw_q;
		run_d    = run_q;
		acc_d    = acc_q;
		line_d   = line_q;
		char_tok = '0;
		char_tok.line_number = line_q;
		char_vld = 1'b0;
		tok0     = flush_tok;
		tok1     = '0;
		push_n   = 2'd0;

		if (mode_q == MODE_HALT) begin
			push_n = 2'd0;
		end else if (in_data.end_of_input) begin
			mode_d = MODE_IDLE;
			push_n = {1'b0, flush_vld};
		end else if (mode_q == MODE_COMMENT) begin
			if (c == CH_NL) begin
				if (line_q != LINE_MAX) line_d = line_q + 1'b1;
				mode_d = MODE_IDLE;
			end
		end else if (mode_q == MODE_NAME && is_letter(c)) begin
			if (run_q < 8'd5) kw_d = {kw_q[KW_BITS-9:0], c};
			if (run_q != 8'hFF) run_d = run_q + 1'b1;
		end else if (mode_q == MODE_NUM && is_digit(c)) begin
			acc_d = add_digit(acc_q, c);
		end else if (mode_q == MODE_EQ && c == CH_EQ) begin
			tok0.token_kind = KIND_EQEQ;
			mode_d = MODE_IDLE;
			push_n = 2'd1;
		end else begin
			// close the pending token, then handle the delimiter itself
			mode_d = MODE_IDLE;
			if (c == CH_NL) begin
				if (line_q != LINE_MAX) line_d = line_q + 1'b1;
			end else if (c == CH_SPACE || c == CH_TAB) begin
				mode_d = MODE_IDLE;
			end else if (c == CH_HASH) begin
				mode_d = MODE_COMMENT;
			end else if (is_letter(c)) begin
				mode_d = MODE_NAME;
				kw_d   = {{(KW_BITS-8){1'b0}}, c};
				run_d  = 8'd1;
			end else if (is_digit(c)) begin
				mode_d = MODE_NUM;
				acc_d  = add_digit('0, c);
			end else if (c == CH_EQ) begin
				mode_d = MODE_EQ;
			end else begin
				char_vld            = 1'b1;
				char_tok.token_kind = punct_kind(c);
				if (char_tok.token_kind == KIND_ERROR) mode_d = MODE_HALT;
			end
			if (flush_vld) begin
				tok1   = char_tok;
				push_n = {char_vld, ~char_vld};
			end else begin
				tok0   = char_tok;
				push_n = {1'b0, char_vld};
			end
		end
		tok0.last_of_run = push_n == 2'd1;
		tok1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			kw_q   <= '0;
			run_q  <= '0;
			acc_q  <= '0;
			line_q <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q <= mode_d;
			kw_q   <= kw_d;
			run_q  <= run_d;
			acc_q  <= acc_d;
			line_q <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (accept ? CNT_BITS'(push_n) : '0) - CNT_BITS'(pop);
		end
	end

	// queue entries carry no reset
	always_ff @(posedge clk) begin
		if (accept && push_n != 2'd0) fifo_q[wr_ptr_q] <= tok0;
		if (accept && push_n == 2'd2) fifo_q[wr_ptr_q + 1'b1] <= tok1;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HALT |-> push_n == 2'd0)
		else $error("token produced while halted");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HALT |=> mode_q == MODE_HALT)
		else $error("left halted mode without reset");

	a_line_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> line_q >= $past(line_q))
		else $error("line counter went backward");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_source_byte_tokenizer.sv -----
// Self-checking testbench for the source byte tokenizer with a token scoreboard.
`timescale 1ns / 1ps

import sbt_pkg::*;

class token_board;
	localparam logic [39:0] KW_PRINT = "print";
	localparam logic [39:0] KW_LET   = "let";
	localparam logic [39:0] KW_IF    = "if";
	localparam logic [39:0] KW_WHILE = "while";
	localparam logic [39:0] KW_FN    = "fn";
	localparam logic [39:0] KW_RET   = "ret";

	mode_t       mode;
	logic [39:0] kw_chars;
	logic [7:0]  run_len;
	logic [31:0] num_acc;
	logic [15:0] line_cnt;
	tok_out_t    due[$];
	tok_out_t    fresh[$];
	int          errors;

	function new();
		mode = MODE_IDLE;
		kw_chars = '0;
		run_len = '0;
		num_acc = '0;
		line_cnt = 16'd1;
		errors = 0;
	endfunction

	function bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function logic [4:0] single_kind(logic [7:0] c);
		case (c)
			";":     return KIND_SEMI;
			"'":     return KIND_QUOTE;
			"+":     return KIND_PLUS;
			"-":     return KIND_MINUS;
			"*":     return KIND_STAR;
			"/":     return KIND_SLASH;
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			",":     return KIND_COMMA;
			"[":     return KIND_LBRACK;
			"]":     return KIND_RBRACK;
			"@":     return KIND_AT;
			default: return KIND_ERROR;
		endcase
	endfunction

	function void emit(logic [4:0] kind, logic [31:0] value, logic [7:0] len);
		tok_out_t t;
		t.token_kind = kind;
		t.number_value = value;
		t.name_length = len;
		t.line_number = line_cnt;
		t.last_of_run = 1'b0;
		fresh.push_back(t);
	endfunction

	function void bump_line();
		if (line_cnt != 16'hFFFF) line_cnt++;
	endfunction

	function void push_digit(logic [7:0] c);
		logic [35:0] w;
		w = {4'h0, num_acc} * 36'd10 + {32'h0, c[3:0]};
		num_acc = (w[35:32] != 4'h0) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	// Emit whatever token is still open and drop back to idle.
	function void flush_pending();
		logic [4:0] kind;
		case (mode)
			MODE_NAME: begin
				kind = KIND_IDENT;
				if (run_len == 8'd5 && kw_chars == KW_PRINT) kind = KIND_PRINT;
				else if (run_len == 8'd3 && kw_chars == KW_LET) kind = KIND_LET;
				else if (run_len == 8'd2 && kw_chars == KW_IF) kind = KIND_IF;
				else if (run_len == 8'd5 && kw_chars == KW_WHILE) kind = KIND_WHILE;
				else if (run_len == 8'd2 && kw_chars == KW_FN) kind = KIND_FN;
				else if (run_len == 8'd3 && kw_chars == KW_RET) kind = KIND_RET;
				emit(kind, 32'd0, run_len);
			end
			MODE_NUM: emit(KIND_NUMBER, num_acc, 8'd0);
			MODE_EQ:  emit(KIND_EQ, 32'd0, 8'd0);
			default: begin
			end
		endcase
		mode = MODE_IDLE;
	endfunction

	function void note_byte(tok_in_t req);
		logic [7:0] c;
		c = req.source_byte;
		fresh.delete();
		if (mode == MODE_HALT) return;
		if (req.end_of_input) begin
			flush_pending();
		end else if (mode == MODE_COMMENT) begin
			if (c == CH_NL) begin
				bump_line();
				mode = MODE_IDLE;
			end
		end else if (mode == MODE_NAME && is_alpha(c)) begin
			// only the first five letters take part in keyword matching
			if (run_len < 8'd5) kw_chars = {kw_chars[31:0], c};
			if (run_len != 8'hFF) run_len++;
		end else if (mode == MODE_NUM && is_num(c)) begin
			push_digit(c);
		end else if (mode == MODE_EQ && c == CH_EQ) begin
			emit(KIND_EQEQ, 32'd0, 8'd0);
			mode = MODE_IDLE;
		end else begin
			flush_pending();
			if (c == CH_NL) begin
				bump_line();
			end else if (c == CH_SPACE || c == CH_TAB) begin
			end else if (c == CH_HASH) begin
				mode = MODE_COMMENT;
			end else if (is_alpha(c)) begin
				mode = MODE_NAME;
				kw_chars = {32'h0, c};
				run_len = 8'd1;
			end else if (is_num(c)) begin
				mode = MODE_NUM;
				num_acc = '0;
				push_digit(c);
			end else if (c == CH_EQ) begin
				mode = MODE_EQ;
			end else begin
				emit(single_kind(c), 32'd0, 8'd0);
				if (single_kind(c) == KIND_ERROR) mode = MODE_HALT;
			end
		end
		if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
		foreach (fresh[i]) due.push_back(fresh[i]);
	endfunction

	function void report(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endfunction

	function void check_token(tok_out_t got);
		tok_out_t want;
		if (due.size() == 0) begin
			errors++;
			$display("%0t: token with none expected, kind %0d value %0d length %0d line %0d",
				$time, got.token_kind, got.number_value, got.name_length, got.line_number);
			return;
		end
		want = due.pop_front();
		if (got.token_kind !== want.token_kind)
			report("token_kind", 32'(want.token_kind), 32'(got.token_kind));
		if (got.number_value !== want.number_value)
			report("number_value", want.number_value, got.number_value);
		if (got.name_length !== want.name_length)
			report("name_length", 32'(want.name_length), 32'(got.name_length));
		if (got.line_number !== want.line_number)
			report("line_number", 32'(want.line_number), 32'(got.line_number));
		if (got.last_of_run !== want.last_of_run)
			report("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
	endfunction

	function int pending();
		return due.size();
	endfunction
endclass

module tb_source_byte_tokenizer;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 850;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	tok_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	tok_out_t    out_data;
	token_board  board = new();
	int          in_pace;
	int          out_pace;
	int unsigned taken;
	int unsigned quiet;
	string       singles = ";'+-*/(),[]@";

	source_byte_tokenizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly zero, sometimes short, rarely long; pace 0 gives no gaps at all.
	function automatic int pick_gap(int pace);
		int r;
		if (pace == 0) return 0;
		r = $urandom_range(0, 99);
		if (r < 100 - 20 * pace) return 0;
		if (r < 97) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic string some_keyword();
		case ($urandom_range(0, 5))
			0:       return "print";
			1:       return "let";
			2:       return "if";
			3:       return "while";
			4:       return "fn";
			default: return "ret";
		endcase
	endfunction

	task automatic put_byte(logic [7:0] b, logic eoi);
		int gap;
		gap = pick_gap(in_pace);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{source_byte: b, end_of_input: eoi};
		do @(posedge clk); while (!in_ready);
		board.note_byte(in_data);
		taken++;
	endtask

	task automatic put_text(string s);
		foreach (s[i]) put_byte(s[i], 1'b0);
	endtask

	task automatic put_fragment();
		int         pick;
		string      s;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			put_text(some_keyword());
		end else if (pick < 26) begin
			if ($urandom_range(0, 4) == 0) begin
				// near misses of keywords
				s = some_keyword();
				case ($urandom_range(0, 2))
					0: begin
						put_text(s);
						put_byte(rand_letter(), 1'b0);
					end
					1: put_text(s.substr(0, s.len() - 2));
					default: begin
						s[0] = s[0] - 8'h20;
						put_text(s);
					end
				endcase
			end else begin
				repeat (($urandom_range(0, 19) == 0) ? $urandom_range(250, 300)
						: $urandom_range(1, 8))
					put_byte(rand_letter(), 1'b0);
			end
		end else if (pick < 38) begin
			case ($urandom_range(0, 19))
				0:       put_text("4294967295");
				1:       put_text("4294967296");
				2:       put_text("0");
				3, 4:    repeat ($urandom_range(9, 14)) put_byte(rand_digit(), 1'b0);
				default: repeat ($urandom_range(1, 4)) put_byte(rand_digit(), 1'b0);
			endcase
		end else if (pick < 55) begin
			put_byte(singles[$urandom_range(0, 11)], 1'b0);
		end else if (pick < 62) begin
			put_byte(CH_EQ, 1'b0);
		end else if (pick < 66) begin
			put_text("==");
		end else if (pick < 78) begin
			put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
		end else if (pick < 86) begin
			put_byte(CH_NL, 1'b0);
		end else if (pick < 92) begin
			// comment body may hold any byte but newline
			put_byte(CH_HASH, 1'b0);
			repeat ($urandom_range(0, 6)) begin
				b = 8'($urandom);
				if (b == CH_NL) b = ~b;
				put_byte(b, 1'b0);
			end
			if ($urandom_range(0, 5) != 0) put_byte(CH_NL, 1'b0);
			else put_byte(8'($urandom), 1'b1);
		end else begin
			put_byte(8'($urandom), 1'b1);
		end
	endtask

	// Result side: accept and check tokens, stall at random, watch for a hang.
	initial begin
		int stall;
		stall = 0;
		quiet = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_token(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap(out_pace);
			end
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int         frag;
		logic [7:0] bad;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		in_pace = 1;
		out_pace = 1;
		taken = 0;
		frag = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_text("if=x==0;'+-*/(),[]@#z\n");
		put_byte(8'hA5, 1'b1);

		while (taken < RANDOM_ITEMS) begin
			if (frag % 12 == 0) begin
				in_pace = $urandom_range(0, 2);
				out_pace = $urandom_range(0, 2);
			end
			put_fragment();
			frag++;
		end
		put_byte(8'($urandom), 1'b1);

		in_pace = 1;
		put_text("x\n7;\nab");
		put_byte(8'($urandom), 1'b1);

		case ($urandom_range(0, 3))
			1: put_text("ab");
			2: put_text("12");
			3: put_byte(CH_EQ, 1'b0);
			default: begin
			end
		endcase
		case ($urandom_range(0, 3))
			0: bad = 8'h00;
			1: bad = 8'h0D;
			default: begin
				do bad = 8'($urandom);
				while (board.is_alpha(bad) || board.is_num(bad) || bad == CH_NL ||
					bad == CH_TAB || bad == CH_SPACE || bad == CH_HASH || bad == CH_EQ ||
					board.single_kind(bad) != KIND_ERROR);
			end
		endcase
		put_byte(bad, 1'b0);
		// halted: these must yield nothing
		put_text("x;\n");
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ----- source_byte_tokenizer.f -----
rtl/sbt_pkg.sv
rtl/source_byte_tokenizer.sv
verif/tb_source_byte_tokenizer.sv
